// File: hdl/fwkr_pkg.sv
// Package with the shared constants, codes and types of the keyed-removal FIFO.
`default_nettype none

package fwkr_pkg;

  // Queue geometry and field widths.
  localparam int unsigned QUEUE_DEPTH   = 16;
  localparam int unsigned ID_BITS       = 16;
  localparam int unsigned DURATION_BITS = 16;
  localparam int unsigned IDX_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W         = $clog2(QUEUE_DEPTH + 1);

  // Command codes.
  typedef enum logic [1:0] {
    CMD_PUSH       = 2'd0,
    CMD_POP        = 2'd1,
    CMD_REMOVE_KEY = 2'd2,
    CMD_MAX        = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Command beat.
  typedef struct packed {
    cmd_e                     command;
    logic [ID_BITS-1:0]       item_id;
    logic [DURATION_BITS-1:0] duration;
  } in_t;

  // Result beat.
  typedef struct packed {
    status_e                  status;
    logic [ID_BITS-1:0]       out_id;
    logic [DURATION_BITS-1:0] out_duration;
    logic [CNT_W-1:0]         fill_level;
  } out_t;

  // Search token that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic                     active;
    logic                     found;
    logic                     has_best;
    logic [ID_BITS-1:0]       best_id;
    logic [DURATION_BITS-1:0] best_dur;
  } tok_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                     push;
    logic                     shift_all;
    logic                     shift_marked;
    logic [CNT_W-1:0]         count;
    logic [DURATION_BITS-1:0] key;
    logic [ID_BITS-1:0]       push_id;
    logic [DURATION_BITS-1:0] push_dur;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/fwkr_cell.sv
// One queue slot: holds a record, shifts toward the head and evaluates the search token.
`default_nettype none

module fwkr_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [fwkr_pkg::IDX_W-1:0]         idx_i,
  input  wire fwkr_pkg::cell_ctrl_t              ctrl_i,
  input  wire fwkr_pkg::tok_t                    tok_i,
  input  wire logic [fwkr_pkg::ID_BITS-1:0]       nxt_id_i,
  input  wire logic [fwkr_pkg::DURATION_BITS-1:0] nxt_dur_i,
  output fwkr_pkg::tok_t                         tok_o,
  output logic [fwkr_pkg::ID_BITS-1:0]            id_o,
  output logic [fwkr_pkg::DURATION_BITS-1:0]      dur_o
);
  import fwkr_pkg::*;

  logic [ID_BITS-1:0]       id_q;
  logic [DURATION_BITS-1:0] dur_q;
  logic                     mark_q, mark_d;
  tok_t                     tok_q, tok_d;
  logic                     occupied;
  logic                     hit;
  logic                     take;

  // The slot holds a record when its position is below the fill count.
  assign occupied = (CNT_W'(idx_i) < ctrl_i.count);

  // Record storage: written by a push at the tail, or takes the younger neighbor on a shift.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (CNT_W'(idx_i) == ctrl_i.count)) begin
      id_q  <= ctrl_i.push_id;
      dur_q <= ctrl_i.push_dur;
    end else if (ctrl_i.shift_all || (ctrl_i.shift_marked && mark_q)) begin
      id_q  <= nxt_id_i;
      dur_q <= nxt_dur_i;
    end
  end

  // Token evaluation: first key match and oldest greatest duration.
  always_comb begin
    tok_d  = tok_i;
    mark_d = mark_q;
    hit    = occupied && !tok_i.found && (dur_q == ctrl_i.key);
    take   = occupied && (!tok_i.has_best || (dur_q > tok_i.best_dur));
    if (tok_i.active) begin
      tok_d.found = tok_i.found || hit;
      mark_d      = occupied && (tok_i.found || hit);
      if (take) begin
        tok_d.has_best = 1'b1;
        tok_d.best_id  = id_q;
        tok_d.best_dur = dur_q;
      end
    end
  end

  // Token stage and removal mark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      mark_q <= 1'b0;
    end else begin
      tok_q  <= tok_d;
      mark_q <= mark_d;
    end
  end

  assign tok_o = tok_q;
  assign id_o  = id_q;
  assign dur_o = dur_q;

endmodule

`default_nettype wire

// File: hdl/fifo_with_keyed_removal_unit.sv
// Top level of the keyed-removal FIFO: command sequencer and the row of slot cells.
// Push and pop need no scan: the result strobe comes in the cycle after the command beat.
// Keyed removal and max query send a token through all QUEUE_DEPTH cells, one per cycle;
// their result is registered once the token leaves the last cell, with busy high until then.
// An empty queue answers any command but push without a scan, in the cycle after the beat.
// Reset empties the queue and clears the sequencer; results are never stalled.
`default_nettype none

module fifo_with_keyed_removal_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire fwkr_pkg::in_t   in_i,
  output logic                 res_valid_o,
  output fwkr_pkg::out_t       result_o
);
  import fwkr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                     state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  cmd_e                     cmd_q;
  logic [DURATION_BITS-1:0] key_q;
  logic                     launch_q;
  logic                     res_valid_q, res_valid_d;
  out_t                     res_q, res_d;
  logic                     accept;
  logic                     is_empty;
  logic                     is_full;
  logic                     scan_done;
  cell_ctrl_t               ctrl;

  tok_t                     tok_w [QUEUE_DEPTH+1];
  logic [ID_BITS-1:0]       id_w  [QUEUE_DEPTH+1];
  logic [DURATION_BITS-1:0] dur_w [QUEUE_DEPTH+1];

  assign accept    = start && !busy;
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign scan_done = (state_q == S_SCAN) && tok_w[QUEUE_DEPTH].active;
  assign busy      = (state_q == S_SCAN);

  // Token entering the head cell in the cycle after a scan command.
  always_comb begin
    tok_w[0]        = '0;
    tok_w[0].active = launch_q;
  end

  // Nothing younger than the last cell.
  assign id_w[QUEUE_DEPTH]  = '0;
  assign dur_w[QUEUE_DEPTH] = '0;

  // Sequencer: decode the command beat and finish scans.
  always_comb begin
    state_d           = state_q;
    count_d           = count_q;
    res_valid_d       = 1'b0;
    res_d             = '0;
    ctrl              = '0;
    ctrl.count        = count_q;
    ctrl.key          = key_q;
    ctrl.push_id      = in_i.item_id;
    ctrl.push_dur     = in_i.duration;
    if (accept) begin
      res_valid_d = 1'b1;
      case (in_i.command)
        CMD_PUSH: begin
          if (is_full) begin
            res_d.status = ST_FULL;
          end else begin
            ctrl.push    = 1'b1;
            count_d      = count_q + CNT_W'(1);
            res_d.status = ST_OK;
          end
        end
        CMD_POP: begin
          if (is_empty) begin
            res_d.status = ST_EMPTY;
          end else begin
            ctrl.shift_all     = 1'b1;
            count_d            = count_q - CNT_W'(1);
            res_d.status       = ST_OK;
            res_d.out_id       = id_w[0];
            res_d.out_duration = dur_w[0];
          end
        end
        default: begin
          if (is_empty) begin
            res_d.status = ST_EMPTY;
          end else begin
            res_valid_d = 1'b0;
            state_d     = S_SCAN;
          end
        end
      endcase
      res_d.fill_level = count_d;
    end else if (scan_done) begin
      state_d     = S_IDLE;
      res_valid_d = 1'b1;
      if (cmd_q == CMD_MAX) begin
        res_d.status       = ST_OK;
        res_d.out_id       = tok_w[QUEUE_DEPTH].best_id;
        res_d.out_duration = tok_w[QUEUE_DEPTH].best_dur;
      end else if (tok_w[QUEUE_DEPTH].found) begin
        ctrl.shift_marked = 1'b1;
        count_d           = count_q - CNT_W'(1);
        res_d.status      = ST_OK;
      end else begin
        res_d.status = ST_NOT_FOUND;
      end
      res_d.fill_level = count_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      launch_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      launch_q    <= accept && (state_d == S_SCAN);
      res_valid_q <= res_valid_d;
    end
  end

  // Command, key and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_i.command;
      key_q <= in_i.duration;
    end
    res_q <= res_d;
  end

  // Row of slot cells, head at index zero.
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    fwkr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IDX_W'(gi)),
      .ctrl_i    (ctrl),
      .tok_i     (tok_w[gi]),
      .nxt_id_i  (id_w[gi+1]),
      .nxt_dur_i (dur_w[gi+1]),
      .tok_o     (tok_w[gi+1]),
      .id_o      (id_w[gi]),
      .dur_o     (dur_w[gi])
    );
  end

  assign res_valid_o = res_valid_q;
  assign result_o    = res_q;

  // The fill count never passes the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  // Ending a scan always delivers its result in the same cycle that busy falls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("scan ended without a result");

  // The token leaves the last cell only while a scan is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_w[QUEUE_DEPTH].active |-> (state_q == S_SCAN))
    else $error("stray search token");

  // A full report comes only with a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (result_o.status == ST_FULL)) |->
      (result_o.fill_level == CNT_W'(QUEUE_DEPTH)))
    else $error("full status with room left");

  // The fill count moves by at most one per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)) ||
    (count_q == $past(count_q) - CNT_W'(1)))
    else $error("fill count jumped");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the keyed-removal FIFO unit.
`timescale 1ns / 1ps

module testbench;
  import fwkr_pkg::*;

  // Shadow copy of the record queue and the results that it predicts.
  class keyed_fifo_scoreboard;
    logic [ID_BITS-1:0]       slot_id[QUEUE_DEPTH];
    logic [DURATION_BITS-1:0] slot_dur[QUEUE_DEPTH];
    int unsigned              held;
    out_t                     expected_results[$];
    int unsigned              failures;

    function new();
      held     = 0;
      failures = 0;
    endfunction

    // Drop the record at pos; the younger records move up one slot.
    function void close_gap(int unsigned pos);
      for (int unsigned i = pos; i + 1 < held; i++) begin
        slot_id[i]  = slot_id[i + 1];
        slot_dur[i] = slot_dur[i + 1];
      end
      held--;
    endfunction

    // Apply one command to the shadow queue and return its result beat.
    function out_t predict_result(in_t beat);
      out_t        res;
      int unsigned best;
      int          hit;
      res        = '0;
      res.status = ST_OK;
      hit        = -1;
      best       = 0;
      if (beat.command == CMD_PUSH) begin
        if (held >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot_id[held]  = beat.item_id;
          slot_dur[held] = beat.duration;
          held++;
        end
      end else if (held == 0) begin
        res.status = ST_EMPTY;
      end else if (beat.command == CMD_POP) begin
        res.out_id       = slot_id[0];
        res.out_duration = slot_dur[0];
        close_gap(0);
      end else if (beat.command == CMD_REMOVE_KEY) begin
        for (int unsigned i = 0; i < held; i++) begin
          if (hit < 0 && slot_dur[i] == beat.duration) hit = i;
        end
        if (hit >= 0) close_gap(hit);
        else res.status = ST_NOT_FOUND;
      end else begin
        // Strictly greater keeps the oldest record on a tie.
        for (int unsigned i = 1; i < held; i++) begin
          if (slot_dur[i] > slot_dur[best]) best = i;
        end
        res.out_id       = slot_id[best];
        res.out_duration = slot_dur[best];
      end
      res.fill_level = CNT_W'(held);
      return res;
    endfunction

    function void note_command(in_t beat);
      expected_results.push_back(predict_result(beat));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing outstanding: %h", got);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        failures++;
      end
      if (got.out_id !== want.out_id) begin
        $error("out_id expected %0h actual %0h", want.out_id, got.out_id);
        failures++;
      end
      if (got.out_duration !== want.out_duration) begin
        $error("out_duration expected %0h actual %0h", want.out_duration, got.out_duration);
        failures++;
      end
      if (got.fill_level !== want.fill_level) begin
        $error("fill_level expected %0d actual %0d", want.fill_level, got.fill_level);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  cmd_beat;
  logic res_valid;
  out_t result;

  keyed_fifo_scoreboard sb;

  fifo_with_keyed_removal_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (cmd_beat),
    .res_valid_o (res_valid),
    .result_o    (result)
  );

  // 2 ns clock.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sample both sides at the rising edge, ahead of the block's own updates.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid) sb.check_result(result);
      if (start && !busy) sb.note_command(cmd_beat);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  // Durations lean on a few corner values so that ties and extremes are common.
  function automatic logic [DURATION_BITS-1:0] pick_duration();
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 5))
        0: return '0;
        1: return DURATION_BITS'(1);
        2: return DURATION_BITS'(2);
        3: return DURATION_BITS'(3);
        4: return DURATION_BITS'({DURATION_BITS{1'b1}} - 1);
        default: return '1;
      endcase
    end
    return DURATION_BITS'($urandom_range(0, 65535));
  endfunction

  // Random command; the fill mode pushes the queue toward full, the drain mode toward empty.
  function automatic in_t make_random_beat(bit fill_mode);
    in_t         beat;
    int unsigned roll;
    roll          = $urandom_range(0, 99);
    beat.item_id  = ID_BITS'($urandom_range(0, 65535));
    beat.duration = pick_duration();
    if (fill_mode) begin
      if (roll < 65) beat.command = CMD_PUSH;
      else if (roll < 75) beat.command = CMD_POP;
      else if (roll < 90) beat.command = CMD_REMOVE_KEY;
      else beat.command = CMD_MAX;
    end else begin
      if (roll < 15) beat.command = CMD_PUSH;
      else if (roll < 55) beat.command = CMD_POP;
      else if (roll < 85) beat.command = CMD_REMOVE_KEY;
      else beat.command = CMD_MAX;
    end
    // Most keys name a duration that is actually held.
    if (beat.command == CMD_REMOVE_KEY && sb.held > 0 && $urandom_range(0, 9) < 7) begin
      beat.duration = sb.slot_dur[$urandom_range(0, sb.held - 1)];
    end
    return beat;
  endfunction

  // Idle for the gap with junk on the bus, then hold the beat until it is taken.
  task automatic drive_beat(input in_t beat, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      start                 = 1'b0;
      cmd_beat.command      = cmd_e'($urandom_range(0, 3));
      cmd_beat.item_id      = ID_BITS'($urandom_range(0, 65535));
      cmd_beat.duration     = DURATION_BITS'($urandom_range(0, 65535));
    end
    @(negedge clk_i);
    start    = 1'b1;
    cmd_beat = beat;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send(input cmd_e cmd, input logic [15:0] id, input logic [15:0] dur);
    in_t beat;
    beat.command  = cmd;
    beat.item_id  = id;
    beat.duration = dur;
    drive_beat(beat, 0);
  endtask

  // Lower start and wait until every outstanding result has come back.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned idle_pct[4];
    bit          fill_mode;
    int unsigned gap;
    idle_pct = '{0, 56, 0, 26};
    sb       = new();
    rst_ni   = 1'b0;
    start    = 1'b0;
    cmd_beat = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: commands on an empty queue.
    send(CMD_POP, 16'h0000, 16'h0000);
    send(CMD_REMOVE_KEY, 16'hFFFF, 16'hFFFF);
    send(CMD_MAX, 16'hFFFF, 16'h0000);
    // All-zero durations: max query must give the front record.
    send(CMD_PUSH, 16'hFFFF, 16'h0000);
    send(CMD_PUSH, 16'h0001, 16'h0000);
    send(CMD_MAX, 16'h0000, 16'h0000);
    // Tie at the top duration: the oldest wins.
    send(CMD_PUSH, 16'h0000, 16'hFFFF);
    send(CMD_PUSH, 16'h1234, 16'hFFFF);
    send(CMD_MAX, 16'h0000, 16'h0000);
    // Absent key, then removal at the front and in the middle.
    send(CMD_REMOVE_KEY, 16'h0000, 16'h5555);
    send(CMD_REMOVE_KEY, 16'h0000, 16'h0000);
    send(CMD_REMOVE_KEY, 16'h0000, 16'hFFFF);
    send(CMD_POP, 16'h0000, 16'h0000);
    // Fill to the brim and push once more.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send(CMD_PUSH, 16'hA5A5 ^ 16'(i), 16'h5A5A + 16'(i));
    end
    drain();

    // Random phases, two with no sender idling and two with some; each ends with a drain of outstanding results.
    fill_mode = 1'b1;
    foreach (idle_pct[p]) begin
      for (int n = 0; n < 475; n++) begin
        gap = 0;
        if ($urandom_range(0, 99) < idle_pct[p]) begin
          gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 22) : $urandom_range(1, 3);
        end
        drive_beat(make_random_beat(fill_mode), gap);
        // Linger a little at full and at empty before turning around.
        if (fill_mode && sb.held == QUEUE_DEPTH && $urandom_range(0, 3) == 0) fill_mode = 1'b0;
        else if (!fill_mode && sb.held == 0 && $urandom_range(0, 3) == 0) fill_mode = 1'b1;
      end
      drain();
    end

    repeat (QUEUE_DEPTH + 8) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
